// ----- rtl/s2lab_pkg.sv -----
package s2lab_pkg;

	localparam int LANES = 3;
	localparam int LIN_W = 31;
	localparam int COEF_W = 24;
	localparam int SUM_W = 54;
	localparam int T_W = 31;
	localparam int F_W = 21;
	localparam int CUBE_STEPS = 21;

	// white divide: top 32 sum bits times a 32-bit reciprocal, then one correction
	localparam int HI_SHIFT = 22;
	localparam int RECIP_SHIFT = 33;
	localparam int REM_W = 26;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [14:0]        lightness;
		logic signed [15:0] green_red;
		logic signed [15:0] blue_yellow;
	} lab_t;

	// rgb to xyz matrix, units of 1e-7, row x/y/z, column r/g/b
	localparam logic [COEF_W-1:0] MATRIX [LANES][LANES] = '{
		'{24'd4124564, 24'd3575761, 24'd1804375},
		'{24'd2126729, 24'd7151522, 24'd721750},
		'{24'd193339, 24'd1191920, 24'd9503041}
	};

	// white point times 1e7
	localparam logic [COEF_W-1:0] XYZ_DIV [LANES] = '{24'd9504560, 24'd10000000, 24'd10887540};

	// floor(2^55 / white)
	localparam logic [31:0] XYZ_RECIP [LANES] = '{
		32'((64'd1 << (HI_SHIFT + RECIP_SHIFT)) / 64'd9504560),
		32'((64'd1 << (HI_SHIFT + RECIP_SHIFT)) / 64'd10000000),
		32'((64'd1 << (HI_SHIFT + RECIP_SHIFT)) / 64'd10887540)
	};

	// q30 linear value of one srgb code, evaluated at elaboration only
	function automatic logic [LIN_W-1:0] lin_value(input int unsigned code);
		longint unsigned c;
		longint unsigned one;
		longint unsigned v;
		longint unsigned v2;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		longint unsigned y2;
		longint unsigned y4;
		longint unsigned p5;
		longint unsigned res;
		c = 64'(code);
		one = 64'd1 << 30;
		if (c <= 64'd10) begin
			res = (c * 64'd10 * one + 64'd16473) / 64'd32946;
		end else begin
			v = ((64'd1000 * c + 64'd14025) * one + 64'd134512) / 64'd269025;
			v2 = (v * v + (one >> 1)) >> 30;
			lo = 64'd0;
			hi = one + 64'd1;
			while (hi - lo > 64'd1) begin
				mid = lo + ((hi - lo) >> 1);
				y2 = (mid * mid) >> 30;
				y4 = (y2 * y2) >> 30;
				p5 = (y4 * mid) >> 30;
				if (p5 <= v2)
					lo = mid;
				else
					hi = mid;
			end
			res = (v2 * lo + (one >> 1)) >> 30;
		end
		return LIN_W'(res);
	endfunction

endpackage

// ----- rtl/s2lab_xyz.sv -----
module s2lab_xyz
	import s2lab_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             pixel_valid,
	input  pixel_t           pixel,
	output logic             sum_valid,
	output logic [SUM_W-1:0] sum [LANES]
);

	wire [LIN_W-1:0] lin_rom [256];

	for (genvar i = 0; i < 256; i++) begin : g_rom
		localparam logic [LIN_W-1:0] LIN = lin_value(i);
		assign lin_rom[i] = LIN;
	end

	logic [LIN_W-1:0]      lin_s1 [LANES];
	logic [LIN_W+COEF_W-1:0] prod_full [LANES][LANES];
	logic [SUM_W-1:0]      prod_s2 [LANES][LANES];
	logic [SUM_W+1:0]      sum_full [LANES];
	logic [SUM_W-1:0]      sum_s3 [LANES];
	logic                  v_s1;
	logic                  v_s2;
	logic                  v_s3;

	always_comb begin
		for (int r = 0; r < LANES; r++) begin
			for (int c = 0; c < LANES; c++)
				prod_full[r][c] = (LIN_W+COEF_W)'(lin_s1[c]) * (LIN_W+COEF_W)'(MATRIX[r][c]);
		end
		// rounding half of the white divisor folded in here
		for (int r = 0; r < LANES; r++) begin
			sum_full[r] = (SUM_W+2)'(prod_s2[r][0]) + (SUM_W+2)'(prod_s2[r][1])
				+ (SUM_W+2)'(prod_s2[r][2]) + (SUM_W+2)'(XYZ_DIV[r] >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lin_s1[0] <= lin_rom[pixel.red];
			lin_s1[1] <= lin_rom[pixel.green];
			lin_s1[2] <= lin_rom[pixel.blue];
			for (int r = 0; r < LANES; r++) begin
				for (int c = 0; c < LANES; c++)
					prod_s2[r][c] <= prod_full[r][c][SUM_W-1:0];
				sum_s3[r] <= sum_full[r][SUM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= pixel_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign sum_valid = v_s3;
	assign sum = sum_s3;

endmodule

// ----- rtl/s2lab_div.sv -----
module s2lab_div
	import s2lab_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             sum_valid,
	input  logic [SUM_W-1:0] sum [LANES],
	output logic             t_valid,
	output logic [T_W-1:0]   t [LANES]
);

	logic [63:0]      est_full [LANES];
	logic [T_W-1:0]   q_est_s1 [LANES];
	logic [REM_W-1:0] n_low_s1 [LANES];
	logic [REM_W-1:0] qd_full [LANES];
	logic [T_W-1:0]   q_est_s2 [LANES];
	logic [REM_W-1:0] n_low_s2 [LANES];
	logic [REM_W-1:0] qd_s2 [LANES];
	logic [REM_W-1:0] rem [LANES];
	logic [T_W-1:0]   q_s3 [LANES];
	logic             v_s1;
	logic             v_s2;
	logic             v_s3;

	// estimate from the top sum bits is the quotient or one below it,
	// so the remainder is under twice the divisor and only low bits matter
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			est_full[l] = 64'(sum[l][SUM_W-1:HI_SHIFT]) * 64'(XYZ_RECIP[l]);
			qd_full[l] = q_est_s1[l][REM_W-1:0] * REM_W'(XYZ_DIV[l]);
			rem[l] = n_low_s2[l] - qd_s2[l];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int l = 0; l < LANES; l++) begin
				q_est_s1[l] <= est_full[l][63:RECIP_SHIFT];
				n_low_s1[l] <= sum[l][REM_W-1:0];
				q_est_s2[l] <= q_est_s1[l];
				n_low_s2[l] <= n_low_s1[l];
				qd_s2[l] <= qd_full[l];
				q_s3[l] <= q_est_s2[l] + T_W'(rem[l] >= REM_W'(XYZ_DIV[l]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s1 <= sum_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign t_valid = v_s3;
	assign t = q_s3;

endmodule

// ----- rtl/s2lab_cie_f.sv -----
module s2lab_cie_f
	import s2lab_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic           t_valid,
	input  logic [T_W-1:0] t [LANES],
	output logic           f_valid,
	output logic [F_W-1:0] f [LANES]
);

	localparam int M_W = 25;
	localparam int N_W = 38;
	localparam int LIN_SHIFT = 13;
	localparam int LIN_RECIP_SHIFT = 33;
	// ceil(2^33 / 145): exact floor division by 145 for any 25-bit value
	localparam logic [25:0] LIN_RECIP = 26'(((64'd1 << 33) + 64'd144) / 64'd145);
	localparam logic [13:0] LIN_MUL = 14'd9033;
	localparam logic [N_W-1:0] LIN_BIAS = N_W'(64'd160 * (64'd1 << 30) + 64'd593920);
	localparam logic [T_W-1:0] T_THRESH = T_W'((64'd8856 << 30) / 64'd1000000);

	typedef struct packed {
		logic [60:0]    target;
		logic [F_W-1:0] y;
		logic [41:0]    sq;
		logic [62:0]    cu;
		logic [M_W-1:0] lrem;
		logic           cube;
	} cube_state_t;

	cube_state_t           prep_s1 [LANES];
	cube_state_t           st_s [CUBE_STEPS][LANES];
	logic [F_W-1:0]        f_s [LANES];
	cube_state_t           prep [LANES];
	logic [N_W-1:0]        lin_num [LANES];
	logic [M_W+25:0]       lin_prod [LANES];
	logic [F_W-1:0]        lin_q [LANES];
	logic                  v_s1;
	logic [CUBE_STEPS-1:0] vld_s;
	logic                  v_f;

	// cube root bit by incremental cube update
	function automatic cube_state_t cube_step(input cube_state_t st, input int k);
		cube_state_t nx;
		logic [63:0] cu_try;
		logic [43:0] sq_try;
		nx = st;
		cu_try = 64'(st.cu) + ((64'(st.sq) * 64'd3) << k) + ((64'(st.y) * 64'd3) << (2 * k))
			+ (64'd1 << (3 * k));
		sq_try = 44'(st.sq) + (44'(st.y) << (k + 1)) + (44'd1 << (2 * k));
		if (cu_try <= 64'(st.target)) begin
			nx.y = st.y | (F_W'(1) << k);
			nx.sq = sq_try[41:0];
			nx.cu = cu_try[62:0];
		end
		return nx;
	endfunction

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			prep[l].cube = t[l] > T_THRESH;
			prep[l].target = {t[l], 30'd0};
			prep[l].y = '0;
			prep[l].sq = '0;
			prep[l].cu = '0;
			// linear branch only matters below the threshold, where t fits in 24 bits
			lin_num[l] = prep[l].cube ? '0 : N_W'(LIN_MUL) * N_W'(t[l][23:0]) + LIN_BIAS;
			prep[l].lrem = lin_num[l][N_W-1:LIN_SHIFT];
			lin_prod[l] = (M_W+26)'(st_s[CUBE_STEPS-1][l].lrem) * (M_W+26)'(LIN_RECIP);
			lin_q[l] = F_W'(lin_prod[l][M_W+25:LIN_RECIP_SHIFT]);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int l = 0; l < LANES; l++) begin
				prep_s1[l] <= prep[l];
				st_s[0][l] <= cube_step(prep_s1[l], CUBE_STEPS - 1);
				for (int s = 1; s < CUBE_STEPS; s++)
					st_s[s][l] <= cube_step(st_s[s-1][l], CUBE_STEPS - 1 - s);
				f_s[l] <= st_s[CUBE_STEPS-1][l].cube ? st_s[CUBE_STEPS-1][l].y : lin_q[l];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			vld_s <= '0;
			v_f <= 1'b0;
		end else if (advance) begin
			v_s1 <= t_valid;
			vld_s <= {vld_s[CUBE_STEPS-2:0], v_s1};
			v_f <= vld_s[CUBE_STEPS-1];
		end
	end

	assign f_valid = v_f;
	assign f = f_s;

endmodule

// ----- rtl/s2lab_lab.sv -----
module s2lab_lab
	import s2lab_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           advance,
	input  logic           f_valid,
	input  logic [F_W-1:0] f [LANES],
	output logic           lab_valid,
	output lab_t           lab
);

	localparam logic signed [29:0] L_OFFSET = 30'sd16777216;
	localparam logic signed [29:0] L_MAX = 30'sd25600;
	localparam logic signed [31:0] AB_MIN = -32'sd32768;
	localparam logic signed [31:0] AB_MAX = 32'sd32767;

	logic signed [29:0] l_raw_s1;
	logic signed [31:0] a_raw_s1;
	logic signed [31:0] b_raw_s1;
	logic signed [21:0] dxy;
	logic signed [21:0] dyz;
	logic signed [29:0] l_rnd;
	logic signed [31:0] a_rnd;
	logic signed [31:0] b_rnd;
	lab_t               lab_next;
	lab_t               lab_s2;
	logic               v_s1;
	logic               v_s2;

	always_comb begin
		dxy = $signed({1'b0, f[0]}) - $signed({1'b0, f[1]});
		dyz = $signed({1'b0, f[1]}) - $signed({1'b0, f[2]});
		// round half up: floor((v + 2048) / 4096) for either sign
		l_rnd = (l_raw_s1 + 30'sd2048) >>> 12;
		a_rnd = (a_raw_s1 + 32'sd2048) >>> 12;
		b_rnd = (b_raw_s1 + 32'sd2048) >>> 12;
		if (l_rnd < 30'sd0)
			lab_next.lightness = '0;
		else if (l_rnd > L_MAX)
			lab_next.lightness = 15'(L_MAX);
		else
			lab_next.lightness = 15'(l_rnd);
		if (a_rnd < AB_MIN)
			lab_next.green_red = 16'(AB_MIN);
		else if (a_rnd > AB_MAX)
			lab_next.green_red = 16'(AB_MAX);
		else
			lab_next.green_red = 16'(a_rnd);
		if (b_rnd < AB_MIN)
			lab_next.blue_yellow = 16'(AB_MIN);
		else if (b_rnd > AB_MAX)
			lab_next.blue_yellow = 16'(AB_MAX);
		else
			lab_next.blue_yellow = 16'(b_rnd);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			l_raw_s1 <= $signed({9'd0, f[1]}) * 30'sd116 - L_OFFSET;
			a_raw_s1 <= 32'(dxy) * 32'sd500;
			b_raw_s1 <= 32'(dyz) * 32'sd200;
			lab_s2 <= lab_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s1 <= f_valid;
			v_s2 <= v_s1;
		end
	end

	assign lab_valid = v_s2;
	assign lab = lab_s2;

endmodule

// ----- rtl/srgb_to_cielab_pixel.sv -----
// srgb to cielab (d65) pixel converter, fixed-point pipeline
// throughput: one pixel per clock while the skid slot is free; most of the
// depth is the 21-step cube root, one bit per stage
// reset clears only valid bits, not buffered data; no state, no clearing pass
module srgb_to_cielab_pixel
	import s2lab_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   pixel_valid,
	output logic   pixel_ready,
	input  pixel_t pixel,
	output logic   lab_valid,
	input  logic   lab_ready,
	output lab_t   lab
);

	logic             advance;
	logic             sum_valid;
	logic [SUM_W-1:0] sum [LANES];
	logic             t_valid;
	logic [T_W-1:0]   t [LANES];
	logic             f_valid;
	logic [F_W-1:0]   f [LANES];
	logic             pipe_valid;
	lab_t             pipe_lab;
	logic             out_valid_q;
	lab_t             out_lab_q;
	logic             skid_valid_q;
	lab_t             skid_lab_q;

	// pipeline moves whenever the skid slot is free
	assign advance = !skid_valid_q;
	assign pixel_ready = advance;

	s2lab_xyz u_xyz (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.pixel_valid (pixel_valid),
		.pixel       (pixel),
		.sum_valid   (sum_valid),
		.sum         (sum)
	);

	s2lab_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.sum_valid (sum_valid),
		.sum       (sum),
		.t_valid   (t_valid),
		.t         (t)
	);

	s2lab_cie_f u_cie_f (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.t_valid (t_valid),
		.t       (t),
		.f_valid (f_valid),
		.f       (f)
	);

	s2lab_lab u_lab (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.f_valid   (f_valid),
		.f         (f),
		.lab_valid (pipe_valid),
		.lab       (pipe_lab)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (lab_ready)
				skid_valid_q <= 1'b0;
		end else if (!out_valid_q || lab_ready) begin
			out_valid_q <= pipe_valid;
		end else if (pipe_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (lab_ready)
				out_lab_q <= skid_lab_q;
		end else if (!out_valid_q || lab_ready) begin
			if (pipe_valid)
				out_lab_q <= pipe_lab;
		end else begin
			skid_lab_q <= pipe_lab;
		end
	end

	assign lab_valid = out_valid_q;
	assign lab = out_lab_q;

endmodule
